// ----- hdl/rspar_pkg.sv -----
// rspar_pkg: shared types, constants and GF(256) arithmetic for the
// Reed-Solomon parity core. No dependencies.
package rspar_pkg;

   localparam logic [8:0] GF_POLY   = 9'h11D;
   localparam logic [7:0] GF_ALPHA  = 8'h02;
   localparam logic [7:0] GF_ONE    = 8'h01;
   localparam int         LEN_RESET = 10;
   localparam int         CSR_W     = 5;

   // per-cycle control broadcast to every cell of the remainder chain
   typedef struct packed {
      logic       init;    // clear remainder, seed monic generator
      logic       build;   // one generator multiply-by-root pass
      logic       step;    // data byte transfer
      logic       last;    // transferred byte ends the block
      logic       shift;   // parity byte transfer, shift output row
      logic [7:0] root;
      logic [7:0] factor;
   } rspar_ctl_type;

   // GF(256) multiply, polynomial 0x11D, msb of b first
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 7; k >= 0; k--) begin
         acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY[7:0] : 8'h00);
         acc = acc ^ (b[k] ? a : 8'h00);
      end
      return acc;
   endfunction

endpackage

// ----- hdl/rspar_if.sv -----
// rspar_if: valid/ready channel interfaces for the Reed-Solomon parity core.
// Depends on nothing.
interface rspar_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rspar_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] parity_byte;
   logic       last_parity;

   modport source (output valid, output parity_byte, output last_parity, input ready);
   modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

// ----- hdl/rspar_cell.sv -----
// rspar_cell: one coefficient slice of the encoder, holding a generator,
// a remainder and an output parity byte. Depends on rspar_pkg.
module rspar_cell (
   input  logic                    clock,
   input  rspar_pkg::rspar_ctl_type ctl,
   input  logic                    seed,
   input  logic [7:0]              gen_nb,
   input  logic [7:0]              rem_nb,
   input  logic [7:0]              par_nb,
   output logic [7:0]              gen_out,
   output logic [7:0]              rem_out,
   output logic [7:0]              par_out
);

   logic [7:0] gen_ff, gen_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] par_ff, par_in;
   logic [7:0] prod;
   logic [7:0] rem_step;

   // one multiplier, shared by generator build and division
   always_comb begin
      prod     = rspar_pkg::gf_mul(gen_ff, ctl.build ? ctl.root : ctl.factor);
      rem_step = rem_nb ^ prod;
   end

   always_comb begin
      if (ctl.init) begin
         gen_in = seed ? rspar_pkg::GF_ONE : 8'h00;
      end else if (ctl.build) begin
         gen_in = prod ^ gen_nb;
      end else begin
         gen_in = gen_ff;
      end

      if (ctl.init || (ctl.step && ctl.last)) begin
         rem_in = 8'h00;
      end else if (ctl.step) begin
         rem_in = rem_step;
      end else begin
         rem_in = rem_ff;
      end

      if (ctl.step && ctl.last) begin
         par_in = rem_step;
      end else if (ctl.shift) begin
         par_in = par_nb;
      end else begin
         par_in = par_ff;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff <= gen_in;
      rem_ff <= rem_in;
      par_ff <= par_in;
   end

   assign gen_out = gen_ff;
   assign rem_out = rem_ff;
   assign par_out = par_ff;

endmodule

// ----- hdl/reed_solomon_parity_gf256_core.sv -----
// Reed-Solomon parity generator over GF(256), polynomial 0x11D, alpha 2.
// Depends on rspar_pkg, rspar_if and rspar_cell.
//
// Takes one data byte per clock on req_chan while ready is high and, after
// the byte marked last, returns parity_length parity bytes on rsp_chan,
// highest coefficient first, with last_parity on the final one. The division
// runs in a row of MAX_PARITY cells, each updating one remainder coefficient
// per accepted byte, so bytes of the next block flow in while the previous
// parity drains. A last byte is held off until the previous block's parity
// has left the output row, so a block shorter than the parity length is
// paced by the parity drain, not by its byte count. After reset and after
// each csr write the generator is rebuilt in place: req_chan.ready stays low
// through the init and build passes and any partly divided block is dropped.
// Lengths of 0 act as 1, lengths above MAX_PARITY act as MAX_PARITY.
module reed_solomon_parity_gf256_core #(
   parameter int MAX_PARITY = 30
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rspar_pkg::CSR_W-1:0]           csr_wdata,
   rspar_req_if.sink                             req_chan,
   rspar_rsp_if.source                           rsp_chan
);

   localparam int LEN_W = $clog2(MAX_PARITY + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PARITY);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_RST =
      (rspar_pkg::LEN_RESET > MAX_PARITY) ? LEN_W'(MAX_PARITY) : LEN_W'(rspar_pkg::LEN_RESET);

   logic [LEN_W-1:0] n_ff, n_in;
   logic             init_ff, init_in;
   logic [LEN_W-1:0] bld_cnt_ff, bld_cnt_in;
   logic [LEN_W-1:0] out_cnt_ff, out_cnt_in;
   logic [7:0]       root_ff, root_in;
   logic [LEN_W-1:0] len_clamped;
   logic             building, load_ok, req_xfer, rsp_xfer, load;

   rspar_pkg::rspar_ctl_type ctl;

   logic [7:0] gen_w [MAX_PARITY+1];
   logic [7:0] rem_w [MAX_PARITY+1];
   logic [7:0] par_w [MAX_PARITY+1];

   always_comb begin
      if (csr_wdata == '0) begin
         len_clamped = LEN_ONE;
      end else if (int'(csr_wdata) > MAX_PARITY) begin
         len_clamped = LEN_MAX;
      end else begin
         len_clamped = LEN_W'(csr_wdata);
      end
   end

   assign building = init_ff || (bld_cnt_ff != '0);
   // a last byte may load the output row only once it is empty or emptying
   assign load_ok  = (out_cnt_ff == '0) || ((out_cnt_ff == LEN_ONE) && rsp_chan.ready);

   assign req_chan.ready = !building && (!req_chan.last_byte || load_ok);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;
   assign load           = req_xfer && req_chan.last_byte;

   always_comb begin
      ctl.init   = init_ff;
      ctl.build  = !init_ff && (bld_cnt_ff != '0);
      ctl.step   = req_xfer;
      ctl.last   = req_chan.last_byte;
      ctl.shift  = rsp_xfer;
      ctl.root   = root_ff;
      ctl.factor = req_chan.data_byte ^ rem_w[0];
   end

   always_comb begin
      n_in       = n_ff;
      init_in    = init_ff;
      bld_cnt_in = bld_cnt_ff;
      root_in    = root_ff;
      if (csr_we) begin
         n_in       = len_clamped;
         init_in    = 1'b1;
         bld_cnt_in = '0;
      end else if (init_ff) begin
         init_in    = 1'b0;
         bld_cnt_in = n_ff;
         root_in    = rspar_pkg::GF_ONE;
      end else if (bld_cnt_ff != '0) begin
         bld_cnt_in = bld_cnt_ff - LEN_ONE;
         root_in    = rspar_pkg::gf_mul(root_ff, rspar_pkg::GF_ALPHA);
      end

      if (load) begin
         out_cnt_in = n_ff;
      end else if (rsp_xfer) begin
         out_cnt_in = out_cnt_ff - LEN_ONE;
      end else begin
         out_cnt_in = out_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff       <= LEN_RST;
         init_ff    <= 1'b1;
         bld_cnt_ff <= '0;
         out_cnt_ff <= '0;
      end else begin
         n_ff       <= n_in;
         init_ff    <= init_in;
         bld_cnt_ff <= bld_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   // the last cell of the row sees zero neighbours beyond it
   assign gen_w[MAX_PARITY] = 8'h00;
   assign rem_w[MAX_PARITY] = 8'h00;
   assign par_w[MAX_PARITY] = 8'h00;

   for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
      rspar_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .seed    (n_ff == LEN_W'(j + 1)),
         .gen_nb  (gen_w[j+1]),
         .rem_nb  (rem_w[j+1]),
         .par_nb  (par_w[j+1]),
         .gen_out (gen_w[j]),
         .rem_out (rem_w[j]),
         .par_out (par_w[j])
      );
   end

   assign rsp_chan.valid       = (out_cnt_ff != '0);
   assign rsp_chan.parity_byte = par_w[0];
   assign rsp_chan.last_parity = (out_cnt_ff == LEN_ONE);

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> out_cnt_ff == $past(n_ff))
      else $error("parity count not loaded with active length");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !load |=> out_cnt_ff == LEN_W'($past(out_cnt_ff) - LEN_ONE))
      else $error("parity count did not step down on transfer");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> init_ff && n_ff != '0 && n_ff <= LEN_MAX)
      else $error("length write did not start a rebuild in range");

   a_build_len: assert property (@(posedge clock) disable iff (reset)
      init_ff && !csr_we |=> bld_cnt_ff == $past(n_ff))
      else $error("generator build not sized to active length");

endmodule

// ----- bench/tb_reed_solomon_parity_gf256_core.sv -----
// Self-checking bench for reed_solomon_parity_gf256_core: a directed table, then random blocks
// under random stalls, scored against an in-bench GF(256) remainder model.
// Depends on rspar_pkg, rspar_if and the core itself.
`timescale 1ns / 100ps

module tb_reed_solomon_parity_gf256_core;

   localparam int MAX_PARITY     = 30;
   localparam int CFG_W          = rspar_pkg::CSR_W;
   localparam int RANDOM_ITEMS   = 395;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [7:0] parity_byte;
      logic       last_parity;
   } parity_type;

   typedef enum bit {ROW_BYTE, ROW_LEN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   value;     // data byte, or the length in the low bits
      logic         last;
      bit           has_fill;  // every parity byte of the block known by eye
      logic [7:0]   fill;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CFG_W-1:0] csr_wdata;

   rspar_req_if req_if ();
   rspar_rsp_if rsp_if ();

   reed_solomon_parity_gf256_core #(.MAX_PARITY(MAX_PARITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // model state
   logic [7:0] gen_coef [0:MAX_PARITY-1];
   logic [7:0] rem_cell [0:MAX_PARITY-1];
   int         par_len;
   parity_type parity_due [$];

   int faults = 0;
   int sent = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   row_type script [0:21] = '{
      '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},   // zero block at reset length
      '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h01, 1'b1, 1'b0, 8'h00},
      '{ROW_LEN,  8'd0,  1'b0, 1'b0, 8'h00},   // zero length acts as one
      '{ROW_BYTE, 8'hA5, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h5A, 1'b1, 1'b1, 8'hFF},   // one cell: parity is the xor of the block
      '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 8'hFF},
      '{ROW_LEN,  8'd31, 1'b0, 1'b0, 8'h00},   // clamps to the maximum
      '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h7F, 1'b1, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h37, 1'b0, 1'b0, 8'h00},
      '{ROW_LEN,  8'd1,  1'b0, 1'b0, 8'h00},   // drops the open block
      '{ROW_BYTE, 8'h3C, 1'b1, 1'b1, 8'h3C},
      '{ROW_LEN,  8'd30, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h12, 1'b1, 1'b0, 8'h00},   // back to back last bytes
      '{ROW_BYTE, 8'hFE, 1'b1, 1'b0, 8'h00},
      '{ROW_LEN,  8'd2,  1'b0, 1'b0, 8'h00},
      '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_LEN,  8'd10, 1'b0, 1'b0, 8'h00}
   };

   // lsb-first shift and add
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p = p ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? rspar_pkg::GF_POLY[7:0] : 8'h00);
      end
      return p;
   endfunction

   task automatic apply_length(input logic [CFG_W-1:0] v);
      logic [7:0] full [0:MAX_PARITY];
      logic [7:0] root;
      int n;
      n = int'(v);
      if (n < 1) n = 1;
      if (n > MAX_PARITY) n = MAX_PARITY;
      par_len = n;
      // full[k] is the coefficient of x^k, multiplied up by (x + root) n times
      foreach (full[k]) full[k] = 8'h00;
      full[0] = rspar_pkg::GF_ONE;
      root = rspar_pkg::GF_ONE;
      for (int i = 0; i < n; i++) begin
         for (int k = i + 1; k >= 1; k--)
            full[k] = full[k-1] ^ gf_times(full[k], root);
         full[0] = gf_times(full[0], root);
         root = gf_times(root, rspar_pkg::GF_ALPHA);
      end
      for (int j = 0; j < MAX_PARITY; j++) begin
         gen_coef[j] = (j < n) ? full[n-1-j] : 8'h00;
         rem_cell[j] = 8'h00;
      end
   endtask

   task automatic divide_byte(input logic [7:0] d, input logic l, input bit has_fill,
                              input logic [7:0] fill);
      logic [7:0] f;
      parity_type e;
      f = d ^ rem_cell[0];
      for (int i = 0; i + 1 < par_len; i++)
         rem_cell[i] = rem_cell[i+1] ^ gf_times(gen_coef[i], f);
      rem_cell[par_len-1] = gf_times(gen_coef[par_len-1], f);
      if (l) begin
         for (int i = 0; i < par_len; i++) begin
            e.parity_byte = has_fill ? fill : rem_cell[i];
            e.last_parity = (i == par_len - 1);
            parity_due = {parity_due, e};
         end
         for (int i = 0; i < MAX_PARITY; i++) rem_cell[i] = 8'h00;
      end
   endtask

   // called and left at a falling edge
   task automatic push_byte(input logic [7:0] d, input logic l, input bit has_fill,
                            input logic [7:0] fill);
      while (!steady && $urandom_range(99) < 6) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= d;
      req_if.last_byte <= l;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      divide_byte(d, l, has_fill, fill);
      sent++;
      steady = (sent >= 150 && sent < 260);
      @(negedge clock);
   endtask

   task automatic write_length(input logic [CFG_W-1:0] v);
      req_if.valid <= 1'b0;
      while (parity_due.size() != 0) @(negedge clock);
      // open blocks leave no result to wait on, so let the core settle
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      apply_length(v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : stimulus
      int nb;
      int blen;
      int nopen;
      int r;
      logic [CFG_W-1:0] lv;
      logic [7:0] d;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      apply_length(CFG_W'(rspar_pkg::LEN_RESET));
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_LEN)
            write_length(script[i].value[CFG_W-1:0]);
         else
            push_byte(script[i].value, script[i].last, script[i].has_fill, script[i].fill);
      end

      hold_request = 1'b1;
      while (sent < $size(script) + RANDOM_ITEMS) begin
         r = $urandom_range(9);
         case (r)
            0: begin
               lv = '0;
            end
            1: begin
               lv = '1;
            end
            2: begin
               lv = CFG_W'(MAX_PARITY);
            end
            3: begin
               lv = CFG_W'($urandom_range(31));
            end
            default: begin
               lv = CFG_W'($urandom_range(8, 1));
            end
         endcase
         write_length(lv);
         nb = $urandom_range(6, 2);
         for (int b = 0; b < nb; b++) begin
            blen = ($urandom_range(7) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
            for (int k = 0; k < blen; k++) begin
               d = 8'($urandom_range(255));
               if ($urandom_range(15) == 0) d = $urandom_range(1) ? 8'hFF : 8'h00;
               push_byte(d, k == blen - 1, 1'b0, 8'h00);
            end
         end
         // sometimes leave a block open for the next length write to drop
         if ($urandom_range(3) == 0) begin
            nopen = $urandom_range(4, 1);
            for (int k = 0; k < nopen; k++)
               push_byte(8'($urandom_range(255)), 1'b0, 1'b0, 8'h00);
         end
      end

      req_if.valid <= 1'b0;
      while (parity_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0 && parity_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      parity_type e;
      if (rsp_if.valid && rsp_if.ready) begin
         if (parity_due.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("unexpected parity transfer: byte %h last %b",
                        rsp_if.parity_byte, rsp_if.last_parity);
         end else begin
            e = parity_due.pop_front();
            if (rsp_if.parity_byte !== e.parity_byte ||
                rsp_if.last_parity !== e.last_parity) begin
               faults++;
               if (faults <= REPORT_LIMIT)
                  $display("parity mismatch: expected byte %h last %b, got byte %h last %b",
                           e.parity_byte, e.last_parity, rsp_if.parity_byte, rsp_if.last_parity);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/rspar_pkg.sv
hdl/rspar_if.sv
hdl/rspar_cell.sv
hdl/reed_solomon_parity_gf256_core.sv
bench/tb_reed_solomon_parity_gf256_core.sv
